[hw/rtl/rgbhsv_pkg.sv]
// Package for the RGB to HSV converter: widths and constants.
// Used by rgbhsv_cell and rgb_to_hsv_converter; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package rgbhsv_pkg;
  localparam int CHAN_W = 8;
  localparam int HUE_W = 16;
  localparam int SAT_W = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int DELTA6_W = 11;   // 6*255 fits in 11 bits
  localparam int DELTA_W = 8;
endpackage
`default_nettype wire

[hw/rtl/rgbhsv_cell.sv]
// One restoring-division cell: one quotient bit per cell for both dividers.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rgbhsv_cell
  import rgbhsv_pkg::*;
#(
  parameter int QW = 24
) (
  input  wire logic                clk,
  input  wire logic                adv,
  input  wire logic                bit_in_h,
  input  wire logic                bit_in_s,
  input  wire logic [DELTA6_W-1:0] hrem_in,
  input  wire logic [DELTA6_W-1:0] hdiv_in,
  input  wire logic [CHAN_W-1:0]   srem_in,
  input  wire logic [CHAN_W-1:0]   sdiv_in,
  input  wire logic [QW-1:0]       hq_in,
  input  wire logic [QW-1:0]       sq_in,
  output logic [DELTA6_W-1:0]      hrem_r,
  output logic [DELTA6_W-1:0]      hdiv_r,
  output logic [CHAN_W-1:0]        srem_r,
  output logic [CHAN_W-1:0]        sdiv_r,
  output logic [QW-1:0]            hq_r,
  output logic [QW-1:0]            sq_r
);
  logic [DELTA6_W:0] htry;
  logic [CHAN_W:0]   stry;
  logic              hge, sge;

  always_comb begin
    htry = {hrem_in, bit_in_h};
    stry = {srem_in, bit_in_s};
    hge  = htry >= {1'b0, hdiv_in};
    sge  = stry >= {1'b0, sdiv_in};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hdiv_r <= hdiv_in;
      sdiv_r <= sdiv_in;
      hrem_r <= hge ? DELTA6_W'(htry - {1'b0, hdiv_in}) : htry[DELTA6_W-1:0];
      srem_r <= sge ? CHAN_W'(stry - {1'b0, sdiv_in}) : stry[CHAN_W-1:0];
      hq_r   <= {hq_in[QW-2:0], hge};
      sq_r   <= {sq_in[QW-2:0], sge};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/rgb_to_hsv_converter.sv]
// Top level of the RGB to HSV converter: front stage, chain of divider cells, output.
// Depends on rgbhsv_pkg and rgbhsv_cell.
//
//   channel | direction | fields
//   in_     | request   | red, green, blue
//   out_    | result    | hue, saturation, brightness, hue_undefined
//
// One pixel per clock while the pipe advances. Stages: one front stage
// (max, min, sector numerator), one divider cell per quotient bit, one output stage.
// The whole pipe advances when the output register is empty or being taken;
// out_stall holds every stage. Reset clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CHAN_W-1:0] in_red,
  input  wire logic [CHAN_W-1:0] in_green,
  input  wire logic [CHAN_W-1:0] in_blue,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [HUE_W-1:0]       out_hue,
  output logic [SAT_W-1:0]       out_saturation,
  output logic [CHAN_W-1:0]      out_brightness,
  output logic                   out_hue_undefined
);
  localparam int N = FRACTION_BITS;
  localparam int QW = FRACTION_BITS + 1;

  // Hue numerator and saturation dividend are shifted in bit by bit from
  // these words; hue = (numer<<N)/full, sat = (delta*(2^N-1))/max.
  logic adv;
  logic [N+1:0] vld_r;

  // front stage
  logic [CHAN_W-1:0] mx, mn, dlt;
  logic [DELTA6_W-1:0] numer;
  logic signed [DELTA6_W+1:0] nsig;
  logic [CHAN_W+N-1:0] sdvd;

  always_comb begin
    mx = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx) mx = in_blue;
    mn = in_red;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn) mn = in_blue;
    dlt = mx - mn;
    if (in_red == mx)
      nsig = $signed({5'b0, in_green}) - $signed({5'b0, in_blue});
    else if (in_green == mx)
      nsig = $signed({4'b0, dlt, 1'b0}) + $signed({5'b0, in_blue})
             - $signed({5'b0, in_red});
    else
      nsig = $signed({3'b0, dlt, 2'b0}) + $signed({5'b0, in_red})
             - $signed({5'b0, in_green});
    if (nsig < 0) nsig = nsig + $signed({2'b0, 11'(6 * dlt)});
    numer = nsig[DELTA6_W-1:0];
    sdvd = ({{N{1'b0}}, dlt} << N) - {{N{1'b0}}, dlt};
  end

  // pipeline registers carrying operands and the shift sources
  logic [DELTA6_W-1:0] f_numer_r [N+1];
  logic [DELTA6_W-1:0] f_full_r  [N+1];
  logic [CHAN_W+N-1:0] f_sdvd_r  [N+1];
  logic [CHAN_W-1:0]   f_mx_r    [N+1];
  logic                f_undef_r [N+1];

  logic [DELTA6_W-1:0] hrem [N+1];
  logic [DELTA6_W-1:0] hdiv [N+1];
  logic [CHAN_W-1:0]   srem [N+1];
  logic [CHAN_W-1:0]   sdiv [N+1];
  logic [QW-1:0]       hq   [N+1];
  logic [QW-1:0]       sq   [N+1];

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;
  assign out_valid = vld_r[N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[N:0], in_valid};
  end

  // Stage 0: the hue dividend starts as numer, whose bits all fit below full,
  // so its remainder seeds the chain; the saturation dividend is shifted in
  // from its top CHAN_W bits already handled: seed with sdvd[top] mod max.
  logic [CHAN_W:0] s0try;
  always_comb s0try = {1'b0, sdvd[CHAN_W+N-1 -: CHAN_W]};

  always_ff @(posedge clk) begin
    if (adv) begin
      f_numer_r[0] <= numer;
      f_full_r[0]  <= 11'(6 * dlt);
      f_sdvd_r[0]  <= sdvd;
      f_mx_r[0]    <= mx;
      f_undef_r[0] <= (mx == '0) || (dlt == '0);
      hrem[0] <= numer;
      hdiv[0] <= (dlt == '0) ? 11'd1 : 11'(6 * dlt);
      // sdvd top bits are delta-1 or zero, so below max, as delta <= max; max is zero only when undefined
      srem[0] <= (s0try >= {1'b0, mx}) ? '0 : sdvd[CHAN_W+N-1 -: CHAN_W];
      sdiv[0] <= (mx == '0) ? 8'd1 : mx;
      hq[0]   <= '0;
      sq[0]   <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    rgbhsv_cell #(.QW(QW)) u_cell (
      .clk      (clk),
      .adv      (adv),
      .bit_in_h (1'b0),
      .bit_in_s (f_sdvd_r[i][N-1-i]),
      .hrem_in  (hrem[i]),
      .hdiv_in  (hdiv[i]),
      .srem_in  (srem[i]),
      .sdiv_in  (sdiv[i]),
      .hq_in    (hq[i]),
      .sq_in    (sq[i]),
      .hrem_r   (hrem[i+1]),
      .hdiv_r   (hdiv[i+1]),
      .srem_r   (srem[i+1]),
      .sdiv_r   (sdiv[i+1]),
      .hq_r     (hq[i+1]),
      .sq_r     (sq[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        f_numer_r[i+1] <= f_numer_r[i];
        f_full_r[i+1]  <= f_full_r[i];
        f_sdvd_r[i+1]  <= f_sdvd_r[i];
        f_mx_r[i+1]    <= f_mx_r[i];
        f_undef_r[i+1] <= f_undef_r[i];
      end
    end
  end

  // output register; drop quotients when undefined
  always_ff @(posedge clk) begin
    if (adv) begin
      out_hue           <= f_undef_r[N] ? '0 : HUE_W'(hq[N]);
      out_saturation    <= f_undef_r[N] ? '0 : SAT_W'(sq[N]);
      out_brightness    <= f_mx_r[N];
      out_hue_undefined <= f_undef_r[N];
    end
  end

  // keep unused pipeline copies referenced
  logic unused_ok;
  assign unused_ok = ^{f_numer_r[N], f_full_r[N], f_sdvd_r[N], hrem[N], hdiv[N],
                       srem[N], sdiv[N]};
endmodule
`default_nettype wire
